[design/assert_macros.svh]
// Assertion macros shared by the window convolution threshold RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[design/wct_pkg.sv]
// Shared types and constants for the 3x3 window convolution threshold block.
// No dependencies; used by the front end, queue, back end, top level and testbench.
`timescale 1ns / 1ps
`default_nettype none

package wct_pkg;

  // field widths
  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int CFG_DATA_W   = 48;
  localparam int CFG_INDEX_W  = 3;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int THRESH_W     = 32;
  localparam int KERNEL_N     = 3;

  // parameter defaults and limits
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_COEF_BITS = 16;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_SIDE      = 3;
  localparam int QUEUE_DEPTH   = 4;

  // register reset values
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  // binary output levels
  localparam logic [PIX_W-1:0] PIX_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_OFF = 8'h00;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KERNEL_TOP = 3'd0,
    REG_KERNEL_MID = 3'd1,
    REG_KERNEL_BOT = 3'd2,
    REG_THRESHOLD  = 3'd3,
    REG_WIDTH      = 3'd4,
    REG_HEIGHT     = 3'd5
  } reg_index_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // channel payloads
  typedef struct packed {
    pixel_t pixel;
  } pixel_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] binary_pixel;
    logic [ROW_W-1:0] centre_row;
    logic [COL_W-1:0] centre_col;
    logic             frame_last;
  } result_item_t;

  // one full window with its centre position, front to back
  typedef struct packed {
    pixel_t [KERNEL_N-1:0][KERNEL_N-1:0] win;  // [row][col], row 0 top, col 2 newest
    logic   [ROW_W-1:0]                  row;
    logic   [COL_W-1:0]                  col;
    logic                                last;
  } window_item_t;

  // configuration groups
  typedef struct packed {
    logic [HEIGHT_REG_W-1:0] height;
    logic [WIDTH_REG_W-1:0]  width;
  } geometry_t;

  typedef struct packed {
    logic [KERNEL_N-1:0][CFG_DATA_W-1:0] rows;  // index 0 is the top row
    logic [THRESH_W-1:0]                 threshold;
  } kernel_cfg_t;

endpackage

`default_nettype wire

[design/wct_stream_if.sv]
// Valid/ready stream interface used for the pixel and result channels.
// Payload type is a parameter; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

interface wct_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/wct_front.sv]
// Front end: raster counters, two line stores and the 3x3 window register.
// Depends on wct_pkg, wct_stream_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wct_front
  import wct_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire geometry_t    geom,
  wct_stream_if.sink        pixels,
  input  wire logic         q_ready,
  output logic              q_push,
  output window_item_t      q_item
);

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = (CNT_W + 1 > WIDTH_REG_W) ? CNT_W + 1 : WIDTH_REG_W;

  // raster position
  logic [CNT_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  // read stage
  logic             f1_valid;
  logic             f1_emit;
  logic             f1_last;
  pixel_t           f1_pixel;
  logic [CNT_W-1:0] f1_addr;
  logic [ROW_W-1:0] f1_row;
  logic [COL_W-1:0] f1_col;
  pixel_t           rd_one;
  pixel_t           rd_two;

  // line stores
  pixel_t line_one_up [MAX_WIDTH];
  pixel_t line_two_up [MAX_WIDTH];

  pixel_t [KERNEL_N-1:0][KERNEL_N-1:0] win;
  pixel_t [KERNEL_N-1:0][KERNEL_N-1:0] win_next;

  logic                    in_fire;
  logic                    f1_done;
  logic [CMP_W-1:0]        w_ext;
  logic [CMP_W-1:0]        w_last;
  logic [HEIGHT_REG_W-1:0] h_last;
  logic                    row_end;
  logic                    frame_end;
  logic                    emit;
  logic [CMP_W-1:0]        col_m1;

  // effective geometry, saturated into the legal range
  always_comb begin
    w_ext = CMP_W'(geom.width);
    if (w_ext < CMP_W'(MIN_SIDE)) begin
      w_last = CMP_W'(MIN_SIDE - 1);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      w_last = CMP_W'(MAX_WIDTH - 1);
    end else begin
      w_last = w_ext - CMP_W'(1);
    end
    if (geom.height < HEIGHT_REG_W'(MIN_SIDE)) begin
      h_last = HEIGHT_REG_W'(MIN_SIDE - 1);
    end else if (geom.height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_last = HEIGHT_REG_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = geom.height - HEIGHT_REG_W'(1);
    end
  end

  // position decode
  assign row_end   = CMP_W'(col_count) >= w_last;
  assign frame_end = row_end && (HEIGHT_REG_W'(row_count) >= h_last);
  assign emit      = (row_count >= ROW_W'(2)) && (col_count >= CNT_W'(2));
  assign col_m1    = CMP_W'(col_count) - CMP_W'(1);

  // handshakes
  assign f1_done      = f1_valid && (!f1_emit || q_ready);
  assign pixels.ready = !f1_valid || f1_done;
  assign in_fire      = pixels.valid && pixels.ready;

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= frame_end ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + CNT_W'(1);
      end
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (in_fire) begin
      f1_valid <= 1'b1;
    end else if (f1_done) begin
      f1_valid <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      f1_emit  <= emit;
      f1_last  <= frame_end;
      f1_pixel <= pixels.data.pixel;
      f1_addr  <= col_count;
      f1_row   <= row_count - ROW_W'(1);
      f1_col   <= col_m1[COL_W-1:0];
    end
  end

  // line store one row up: read old entry, write the new pixel
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_one                 <= line_one_up[col_count];
      line_one_up[col_count] <= pixels.data.pixel;
    end
  end

  // line store two rows up: takes the entry moved out of the first store
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_two <= line_two_up[col_count];
    end
    if (f1_done) begin
      line_two_up[f1_addr] <= rd_one;
    end
  end

  // window shift by one column
  always_comb begin
    for (int i = 0; i < KERNEL_N; i++) begin
      for (int j = 0; j < KERNEL_N - 1; j++) begin
        win_next[i][j] = win[i][j+1];
      end
    end
    win_next[0][KERNEL_N-1] = rd_two;
    win_next[1][KERNEL_N-1] = rd_one;
    win_next[2][KERNEL_N-1] = f1_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (f1_done) begin
      win <= win_next;
    end
  end

  // request towards the queue
  assign q_push      = f1_valid && f1_emit && q_ready;
  assign q_item.win  = win_next;
  assign q_item.row  = f1_row;
  assign q_item.col  = f1_col;
  assign q_item.last = f1_last;

  `ASSERT_IMPLY(a_accept_frees_stage, clk, rst, in_fire && f1_valid, f1_done)

endmodule

`default_nettype wire

[design/wct_queue.sv]
// Short queue of complete windows between the front end and the arithmetic.
// Depends on wct_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wct_queue
  import wct_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire window_item_t push_item,
  output logic              push_ready,
  input  wire logic         pop,
  output logic              pop_valid,
  output window_item_t      pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  window_item_t     slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_IMPLY(a_no_push_when_full, clk, rst, push, push_ready)
  `ASSERT_IMPLY(a_no_pop_when_empty, clk, rst, pop, pop_valid)

endmodule

`default_nettype wire

[design/wct_back.sv]
// Arithmetic back end: nine products, row sums, total, threshold compare.
// Depends on wct_pkg, wct_stream_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wct_back
  import wct_pkg::*;
#(
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire kernel_cfg_t  kcfg,
  input  wire logic         q_valid,
  input  wire window_item_t q_item,
  output logic              q_pop,
  wct_stream_if.source      results
);

  localparam int PROD_W = COEF_BITS + PIX_W + 1;
  localparam int SUM_W  = PROD_W + 4;
  localparam int CMP_W  = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
  localparam int EXT_W  = KERNEL_N * COEF_BITS + CFG_DATA_W;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pos_t;

  logic signed [COEF_BITS-1:0] coef [KERNEL_N][KERNEL_N];

  // pipeline registers
  logic                     p_valid;
  pos_t                     p_pos;
  logic signed [PROD_W-1:0] prod [KERNEL_N][KERNEL_N];
  logic                     r_valid;
  pos_t                     r_pos;
  logic signed [SUM_W-1:0]  rsum [KERNEL_N];
  logic                     t_valid;
  pos_t                     t_pos;
  logic signed [SUM_W-1:0]  total;
  logic                     o_valid;
  result_item_t             o_item;

  logic                     adv;
  logic signed [PROD_W-1:0] prod_next [KERNEL_N][KERNEL_N];
  logic signed [SUM_W-1:0]  rsum_next [KERNEL_N];
  logic signed [SUM_W-1:0]  total_next;
  logic signed [CMP_W-1:0]  sum_cmp;
  logic signed [CMP_W-1:0]  thr_cmp;

  assign adv   = !o_valid || results.ready;
  assign q_pop = adv && q_valid;

  // coefficient fields, left column in the lowest bits
  always_comb begin
    logic [EXT_W-1:0] row_ext;
    for (int i = 0; i < KERNEL_N; i++) begin
      row_ext = EXT_W'(kcfg.rows[i]);
      for (int j = 0; j < KERNEL_N; j++) begin
        coef[i][j] = $signed(row_ext[j*COEF_BITS +: COEF_BITS]);
      end
    end
  end

  // products
  always_comb begin
    logic signed [PROD_W-1:0] a;
    logic signed [PROD_W-1:0] b;
    for (int i = 0; i < KERNEL_N; i++) begin
      for (int j = 0; j < KERNEL_N; j++) begin
        a = PROD_W'(coef[i][j]);
        b = PROD_W'($signed({1'b0, q_item.win[i][j]}));
        prod_next[i][j] = a * b;
      end
    end
  end

  // row sums
  always_comb begin
    for (int i = 0; i < KERNEL_N; i++) begin
      rsum_next[i] = SUM_W'(prod[i][0]) + SUM_W'(prod[i][1]) + SUM_W'(prod[i][2]);
    end
  end

  assign total_next = rsum[0] + rsum[1] + rsum[2];
  assign sum_cmp    = CMP_W'(total);
  assign thr_cmp    = CMP_W'($signed(kcfg.threshold));

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      r_valid <= 1'b0;
      t_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= q_valid;
      r_valid <= p_valid;
      t_valid <= r_valid;
      o_valid <= t_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      p_pos <= '{row: q_item.row, col: q_item.col, last: q_item.last};
      prod  <= prod_next;
      r_pos <= p_pos;
      rsum  <= rsum_next;
      t_pos <= r_pos;
      total <= total_next;
      o_item.binary_pixel <= (sum_cmp > thr_cmp) ? PIX_ON : PIX_OFF;
      o_item.centre_row   <= t_pos.row;
      o_item.centre_col   <= t_pos.col;
      o_item.frame_last   <= t_pos.last;
    end
  end

  assign results.valid = o_valid;
  assign results.data  = o_item;

  `ASSERT_NEXT(a_total_reaches_output, clk, rst, adv && t_valid, o_valid)

endmodule

`default_nettype wire

[design/window_convolution_threshold.sv]
// 3x3 window correlation with binary threshold over a raster pixel stream.
// Throughput: one pixel per clock while the result side takes results.
// Path: the pixel that completes a window is registered in the read stage, then passes
// through the queue and the product, row sum, total and output registers.
// Reset: counters, window, queue and pipeline clear; registers take defaults;
// line stores are not cleared (the first two rows of a frame give no result).
`timescale 1ns / 1ps
`default_nettype none

module window_convolution_threshold
  import wct_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  wct_stream_if.sink                  pixels,
  wct_stream_if.source                results,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  geometry_t    geom;
  kernel_cfg_t  kcfg;
  logic         q_push;
  logic         q_ready;
  logic         q_valid;
  logic         q_pop;
  window_item_t q_in;
  window_item_t q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kcfg        <= '0;
      geom.width  <= WIDTH_RESET;
      geom.height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KERNEL_TOP: kcfg.rows[0]   <= cfg_data;
        REG_KERNEL_MID: kcfg.rows[1]   <= cfg_data;
        REG_KERNEL_BOT: kcfg.rows[2]   <= cfg_data;
        REG_THRESHOLD:  kcfg.threshold <= cfg_data[THRESH_W-1:0];
        REG_WIDTH:      geom.width     <= cfg_data[WIDTH_REG_W-1:0];
        REG_HEIGHT:     geom.height    <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  wct_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .pixels  (pixels),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_item  (q_in)
  );

  wct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_out)
  );

  wct_back #(
    .COEF_BITS (COEF_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .kcfg    (kcfg),
    .q_valid (q_valid),
    .q_item  (q_out),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

`default_nettype wire

[dv/tb_window_convolution_threshold.sv]
// Self-checking testbench for the 3x3 window convolution threshold block.
// Needs wct_pkg, wct_stream_if and window_convolution_threshold from the design folder.
// A scoreboard class predicts each result from the accepted pixels and checks it in order.
`timescale 1ns / 1ps
`default_nettype none

module tb_window_convolution_threshold;
  import wct_pkg::*;

  localparam int LINE_DEPTH    = DEF_MAX_WIDTH;
  localparam int COEF_W        = DEF_COEF_BITS;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 900;
  localparam int MAX_REPORTS   = 40;

  // register indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] UNMAPPED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] UNMAPPED_HI = 3'd7;

  // predicts results from accepted pixels and checks them in arrival order
  class threshold_scoreboard;
    logic [CFG_DATA_W-1:0]      kernel_rows [KERNEL_N];
    logic signed [THRESH_W-1:0] threshold_value;
    logic [WIDTH_REG_W-1:0]     width_reg;
    logic [HEIGHT_REG_W-1:0]    height_reg;
    pixel_t                     line_one_up [LINE_DEPTH];
    pixel_t                     line_two_up [LINE_DEPTH];
    pixel_t                     window [KERNEL_N][KERNEL_N];
    int unsigned                col_count;
    int unsigned                row_count;
    result_item_t               expected_results [$];
    int unsigned                mismatches;
    int unsigned                results_checked;
    int unsigned                pixels_noted;
    int unsigned                frames_seen;

    function new();
      for (int i = 0; i < KERNEL_N; i++) begin
        kernel_rows[i] = '0;
        for (int j = 0; j < KERNEL_N; j++) window[i][j] = '0;
      end
      for (int k = 0; k < LINE_DEPTH; k++) begin
        line_one_up[k] = '0;
        line_two_up[k] = '0;
      end
      threshold_value = '0;
      width_reg       = WIDTH_RESET;
      height_reg      = HEIGHT_RESET;
      col_count       = 0;
      row_count       = 0;
      mismatches      = 0;
      results_checked = 0;
      pixels_noted    = 0;
      frames_seen     = 0;
    endfunction

    function void apply_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_KERNEL_TOP, REG_KERNEL_MID, REG_KERNEL_BOT: kernel_rows[index] = value;
        REG_THRESHOLD: threshold_value = value[THRESH_W-1:0];
        REG_WIDTH:     width_reg = value[WIDTH_REG_W-1:0];
        REG_HEIGHT:    height_reg = value[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg < MIN_SIDE) return MIN_SIDE;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < MIN_SIDE) return MIN_SIDE;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function bit at_frame_start();
      return col_count == 0 && row_count == 0;
    endfunction

    function int unsigned pixels_to_frame_end();
      int unsigned w, h, n;
      w = eff_width();
      h = eff_height();
      n = (col_count >= w - 1) ? 1 : w - col_count;
      if (row_count < h - 1) n += (h - 1 - row_count) * w;
      return n;
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    // advance the raster position by one pixel and queue the result it completes
    function void note_pixel(pixel_t px);
      int unsigned w, h, c, r;
      pixel_t above_two, above_one;
      bit row_end, frame_end;
      longint total;
      logic signed [COEF_W-1:0] coef;
      result_item_t exp_item;
      w = eff_width();
      h = eff_height();
      c = col_count % LINE_DEPTH;
      r = row_count;
      above_two = line_two_up[c];
      above_one = line_one_up[c];
      row_end   = (c >= w - 1);
      frame_end = row_end && (r >= h - 1);
      pixels_noted++;

      // shift the window left, newest column from the line stores and the pixel
      for (int i = 0; i < KERNEL_N; i++)
        for (int j = 0; j < KERNEL_N - 1; j++) window[i][j] = window[i][j + 1];
      window[0][KERNEL_N - 1] = above_two;
      window[1][KERNEL_N - 1] = above_one;
      window[2][KERNEL_N - 1] = px;
      line_two_up[c] = above_one;
      line_one_up[c] = px;

      // interior centre: correlation sum against the threshold
      if (r >= 2 && c >= 2) begin
        total = 0;
        for (int i = 0; i < KERNEL_N; i++)
          for (int j = 0; j < KERNEL_N; j++) begin
            coef = kernel_rows[i][j * COEF_W +: COEF_W];
            total += longint'(coef) * longint'(window[i][j]);
          end
        exp_item.binary_pixel = (total > longint'(threshold_value)) ? PIX_ON : PIX_OFF;
        exp_item.centre_row   = ROW_W'(r - 1);
        exp_item.centre_col   = COL_W'(c - 1);
        exp_item.frame_last   = frame_end;
        expected_results.push_back(exp_item);
      end

      if (row_end) begin
        col_count = 0;
        row_count = frame_end ? 0 : ((r + 1) & 12'hFFF);
      end else begin
        col_count = (c + 1) & 10'h3FF;
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(result_item_t got);
      result_item_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result request at row %0d col %0d",
                                  got.centre_row, got.centre_col));
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      if (got.frame_last === 1'b1) frames_seen++;
      if (got.binary_pixel !== want.binary_pixel)
        report_mismatch($sformatf("binary_pixel %0h, want %0h at row %0d col %0d",
                                  got.binary_pixel, want.binary_pixel,
                                  want.centre_row, want.centre_col));
      if (got.centre_row !== want.centre_row)
        report_mismatch($sformatf("centre_row %0d, want %0d", got.centre_row,
                                  want.centre_row));
      if (got.centre_col !== want.centre_col)
        report_mismatch($sformatf("centre_col %0d, want %0d at row %0d", got.centre_col,
                                  want.centre_col, want.centre_row));
      if (got.frame_last !== want.frame_last)
        report_mismatch($sformatf("frame_last %0b, want %0b at row %0d col %0d",
                                  got.frame_last, want.frame_last,
                                  want.centre_row, want.centre_col));
    endtask

    task flush_leftovers();
      if (expected_results.size() != 0) begin
        report_mismatch($sformatf("%0d expected result requests never arrived",
                                  expected_results.size()));
        expected_results.delete();
      end
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bit          gaps_on;
  int          hold_request;
  int unsigned cycle_count;
  int unsigned cfg_writes;
  int unsigned random_sent;
  threshold_scoreboard board;

  wct_stream_if #(.payload_t(pixel_item_t))  pix_if ();
  wct_stream_if #(.payload_t(result_item_t)) res_if ();

  window_convolution_threshold dut (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pix_if),
    .results   (res_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, plus long hold-offs on request from the stimulus
  initial begin : result_sink
    int stall_left, hold_left;
    stall_left = 0;
    hold_left  = 0;
    res_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        board.check_result(res_if.data);
        stall_left = gaps_on ? $urandom_range(0, 3) : 0;
      end
    end
  end

  // offer one pixel request and wait until it is taken
  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid      <= 1'b1;
    pix_if.data.pixel <= p;
    do @(posedge clk); while (!pix_if.ready);
    board.note_pixel(p);
  endtask

  function automatic pixel_t random_pixel();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  // wait for outstanding results, bounded so a lost result cannot hang the run
  task automatic drain_results(input int unsigned limit);
    int unsigned waited;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (board.outstanding() != 0 && waited < limit);
    board.flush_leftovers();
  endtask

  // idle point: results in, border pixels through the pipeline
  task automatic settle();
    drain_results(DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_burst(input int n, input int pause_at);
    for (int k = 0; k < n; k++) begin
      // sender holds back until every expected result is in
      if (k == pause_at) begin
        pix_if.valid <= 1'b0;
        drain_results(DRAIN_LIMIT);
      end
      send_pixel(random_pixel());
    end
    pix_if.valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    board.apply_register(idx, value);
    cfg_write <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  // half the time, junk above the register's own width
  function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] v,
                                                       input int bits);
    logic [CFG_DATA_W-1:0] mask;
    mask = ~((CFG_DATA_W'(1) << bits) - 1);
    if ($urandom_range(0, 1)) v = v | (CFG_DATA_W'({$urandom, $urandom}) & mask);
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_row(input logic [COEF_W-1:0] left,
                                                     input logic [COEF_W-1:0] mid,
                                                     input logic [COEF_W-1:0] right);
    return {right, mid, left};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_kernel_row();
    logic [CFG_DATA_W-1:0] row;
    int style;
    style = $urandom_range(0, 7);
    for (int k = 0; k < KERNEL_N; k++) begin
      case (style)
        0, 1, 2: row[k * COEF_W +: COEF_W] = COEF_W'($urandom);
        7:       row[k * COEF_W +: COEF_W] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        // Q3.12 taps between -2.0 and 2.0
        default: row[k * COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 16384) - 8192);
      endcase
    end
    return row;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_threshold();
    logic [THRESH_W-1:0] t;
    case ($urandom_range(0, 11))
      0:       t = 32'h8000_0000;
      1:       t = 32'h7FFF_FFFF;
      default: t = THRESH_W'($urandom_range(0, 1 << 25) - (1 << 24));
    endcase
    return with_noise(CFG_DATA_W'(t), THRESH_W);
  endfunction

  function automatic int pick_width();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2);
      1:       return $urandom_range(13, 64);
      default: return $urandom_range(3, 12);
    endcase
  endfunction

  function automatic int pick_height();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 2);
      default: return $urandom_range(3, 8);
    endcase
  endfunction

  task automatic write_random_kernel();
    write_reg(REG_KERNEL_TOP, random_kernel_row());
    write_reg(REG_KERNEL_MID, random_kernel_row());
    write_reg(REG_KERNEL_BOT, random_kernel_row());
  endtask

  initial begin : stimulus
    int count, pause_at, phase;
    board = new();
    pix_if.valid <= 1'b0;
    pix_if.data  <= '0;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    gaps_on      = 1'b1;
    hold_request = 0;
    cfg_writes   = 0;
    random_sent  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry: part of a 640-wide row, then a narrower, shorter frame mid-row
    write_random_kernel();
    write_reg(REG_THRESHOLD, random_threshold());
    send_burst(10, -1);
    settle();
    write_reg(REG_WIDTH, with_noise(16, WIDTH_REG_W));
    write_reg(REG_HEIGHT, with_noise(4, HEIGHT_REG_W));
    hold_request = 300;
    send_burst(board.pixels_to_frame_end(), -1);
    settle();

    // tap minimum, threshold minimum, clamped width
    write_reg(REG_WIDTH, with_noise(0, WIDTH_REG_W));
    write_reg(REG_HEIGHT, with_noise(4, HEIGHT_REG_W));
    write_reg(REG_KERNEL_TOP, {KERNEL_N{16'h8000}});
    write_reg(REG_KERNEL_MID, {KERNEL_N{16'h8000}});
    write_reg(REG_KERNEL_BOT, {KERNEL_N{16'h8000}});
    write_reg(REG_THRESHOLD, CFG_DATA_W'(32'h8000_0000));
    repeat (9) send_pixel(8'hFF);
    pix_if.valid <= 1'b0;
    settle();

    // tap maximum, threshold maximum, last row of the same frame
    write_reg(REG_KERNEL_TOP, {KERNEL_N{16'h7FFF}});
    write_reg(REG_KERNEL_MID, {KERNEL_N{16'h7FFF}});
    write_reg(REG_KERNEL_BOT, {KERNEL_N{16'h7FFF}});
    write_reg(REG_THRESHOLD, CFG_DATA_W'(32'h7FFF_FFFF));
    repeat (3) send_pixel(8'hFF);
    pix_if.valid <= 1'b0;
    settle();

    // distinct taps catch flips and swaps; the first window sum equals the threshold
    write_reg(REG_WIDTH, with_noise(4, WIDTH_REG_W));
    write_reg(REG_HEIGHT, with_noise(2, HEIGHT_REG_W));
    write_reg(REG_KERNEL_TOP, pack_row(1, 2, 3));
    write_reg(REG_KERNEL_MID, pack_row(4, 5, 6));
    write_reg(REG_KERNEL_BOT, pack_row(7, 8, 9));
    write_reg(REG_THRESHOLD, CFG_DATA_W'(348));
    for (int k = 1; k <= 12; k++) send_pixel(pixel_t'(k));
    pix_if.valid <= 1'b0;
    settle();

    // geometry clamped from above, then narrowed mid-row past the new last column
    gaps_on = $urandom_range(0, 1);
    write_random_kernel();
    write_reg(REG_THRESHOLD, random_threshold());
    write_reg(REG_WIDTH, with_noise(11'h7FF, WIDTH_REG_W));
    write_reg(REG_HEIGHT, with_noise(13'h1FFF, HEIGHT_REG_W));
    send_burst(20, -1);
    settle();
    write_reg(REG_WIDTH, with_noise(12, WIDTH_REG_W));
    write_reg(REG_HEIGHT, with_noise(3, HEIGHT_REG_W));
    send_burst(board.pixels_to_frame_end(), -1);
    settle();

    // random phases of small frames, registers rewritten at idle points
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) write_random_kernel();
      if ($urandom_range(0, 2) == 0) write_reg(REG_THRESHOLD, random_threshold());
      if (board.at_frame_start()) begin
        if ($urandom_range(0, 1)) write_reg(REG_WIDTH, with_noise(pick_width(), WIDTH_REG_W));
        if ($urandom_range(0, 1))
          write_reg(REG_HEIGHT, with_noise(pick_height(), HEIGHT_REG_W));
      end else if ($urandom_range(0, 4) == 0) begin
        // mid-frame: width may only shrink, so line stores are never read unwritten
        if ($urandom_range(0, 1))
          write_reg(REG_WIDTH, with_noise($urandom_range(0, board.eff_width()), WIDTH_REG_W));
        else
          write_reg(REG_HEIGHT, with_noise(pick_height(), HEIGHT_REG_W));
      end
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? UNMAPPED_HI : UNMAPPED_LO,
                  CFG_DATA_W'({$urandom, $urandom}));

      count = board.pixels_to_frame_end();
      if (count > 300 || $urandom_range(0, 1)) count = $urandom_range(1, 60);
      if (phase % 8 == 3) begin
        hold_request = $urandom_range(150, 300);
        count = $urandom_range(40, 80);
      end
      pause_at = (phase % 5 == 2) ? count / 2 : -1;
      send_burst(count, pause_at);
      random_sent += count;
      settle();
      phase++;
    end

    drain_results(DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.flush_leftovers();

    $display("run covered %0d pixel requests (%0d in random phases) and %0d result requests",
             board.pixels_noted, random_sent, board.results_checked);
    $display("%0d frames closed, %0d register writes, %0d mismatches",
             board.frames_seen, cfg_writes, board.mismatches);
    if (board.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
